// ----- design/fned_pkg.sv -----
// fned_pkg: types, character constants and escape table for the file name escape decoder
// no dependencies
`timescale 1ns / 1ps

package fned_pkg;

   localparam logic [7:0] CHR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHR_DASH       = 8'h2D;
   localparam logic [7:0] CHR_ZERO       = 8'h30;
   localparam logic [7:0] CHR_NINE       = 8'h39;
   localparam logic [7:0] CHR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHR_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CHR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHR_LOWER_V    = 8'h76;
   localparam logic [7:0] CHR_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CASE_OFFSET    = 8'h20;
   localparam logic [7:0] CTRL_LETTER_BASE = 8'd10;

   typedef enum logic [1:0] {
      ESC_SYMBOL,
      ESC_TOGGLE,
      ESC_CONTROL,
      ESC_INVALID
   } esc_kind_type;

   typedef struct packed {
      esc_kind_type kind;
      logic [7:0]   symbol;
   } esc_result_type;

   // per-name decoder flags
   typedef struct packed {
      logic after_escape;
      logic control_pending;
      logic upper_mode;
      logic error_seen;
   } dec_state_type;

   localparam dec_state_type STATE_RESET = '{
      after_escape:    1'b0,
      control_pending: 1'b0,
      upper_mode:      1'b1,
      error_seen:      1'b0
   };

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       name_end;
      logic       name_bad;
   } dec_result_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) ? c + CASE_OFFSET : c;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) ? c - CASE_OFFSET : c;
   endfunction

   // character after an underscore, matched case-blind
   function automatic esc_result_type escape_lookup(input logic [7:0] c);
      esc_result_type r;
      r.kind   = ESC_SYMBOL;
      r.symbol = 8'h00;
      unique case (to_lower(c))
         8'h73:          r.symbol = 8'h2F;  // s -> /
         8'h62:          r.symbol = 8'h5C;  // b -> backslash
         8'h63:          r.symbol = 8'h3A;  // c -> :
         8'h61:          r.symbol = 8'h2A;  // a -> *
         8'h71:          r.symbol = 8'h3F;  // q -> ?
         8'h64:          r.symbol = 8'h22;  // d -> double quote
         8'h6C:          r.symbol = 8'h3C;  // l -> <
         8'h67:          r.symbol = 8'h3E;  // g -> >
         8'h70:          r.symbol = 8'h7C;  // p -> |
         CHR_UNDERSCORE: r.symbol = 8'h20;  // _ -> space
         8'h78:          r.symbol = 8'h2E;  // x -> .
         8'h75:          r.symbol = CHR_UNDERSCORE;  // u -> _
         CHR_DASH:       r.kind   = ESC_TOGGLE;
         8'h6E:          r.kind   = ESC_CONTROL;  // n
         default:        r.kind   = ESC_INVALID;
      endcase
      return r;
   endfunction

endpackage

// ----- design/file_name_escape_decoder.sv -----
// file_name_escape_decoder: top level, input register, decode, result register
// depends on fned_pkg and fned_decode
`timescale 1ns / 1ps

// Decodes an escaped file name one byte per item and gives exactly one result
// item per input item. An underscore escapes the next byte (case-blind): one
// of twelve symbols, '-' to toggle the letter case, or 'n' to start a control
// code whose next plain byte ('0'-'9', 'a'-'v') gives a value of 0 to 31.
// Plain letters are forced to the current case, which starts as upper; bytes
// of 128 and above pass through as non-letters. The first error in a name
// silences output until the byte flagged last_of_name, whose result carries
// name_end and, if the name was bad or ended inside an escape, name_bad.
// All flags return to their reset values after each name.
// Rate: one item per cycle sustained while rsp_ready stays high. An accepted
// item passes from the input register through the single decode pass into
// the result register and then shows on rsp_; the flags are updated at the
// same edge as the result register is loaded.
// Both stages hold their item under back-pressure, so up to two items sit
// in the block while rsp_ready is low.
module file_name_escape_decoder (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_of_name,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_name_end,
   output logic       rsp_name_bad
);
   import fned_pkg::*;

   // input register
   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff, in_byte_in;
   logic           in_last_ff, in_last_in;

   // per-name flags
   dec_state_type  state_ff, state_in;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   dec_result_type rsp_ff, rsp_in;

   dec_state_type  dec_state;
   dec_result_type dec_result;
   logic           advance;

   // result slot is free or being emptied this cycle
   assign advance   = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   fned_decode u_decode (
      .in_byte      (in_byte_ff),
      .last_of_name (in_last_ff),
      .state_cur    (state_ff),
      .state_nxt    (dec_state),
      .result       (dec_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_byte_in  = req_in_byte;
         in_last_in  = req_last_of_name;
      end
   end

   // flags move only when the item in the input register is decoded
   always_comb begin
      state_in     = advance ? dec_state : state_ff;
      rsp_in       = advance ? dec_result : rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_ff.out_byte;
   assign rsp_out_valid = rsp_ff.out_valid;
   assign rsp_name_end  = rsp_ff.name_end;
   assign rsp_name_bad  = rsp_ff.name_bad;

   // a bad flag only ever rides on the last byte of a name
   a_bad_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_name_bad |-> rsp_name_end)
      else $error("name_bad without name_end");

   // a silent result carries a zero byte
   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_byte == 8'h00)
      else $error("suppressed result with nonzero byte");

   // decoding the last byte of a name restores the flags
   a_flags_reset: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff == STATE_RESET)
      else $error("flags not restored after name end");

   // while an error is pending nothing is emitted
   a_error_silent: assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.error_seen |=> rsp_valid && !rsp_out_valid)
      else $error("output after error");

endmodule

// ----- design/fned_decode.sv -----
// fned_decode: combinational decode of one byte against the per-name flags
// depends on fned_pkg
`timescale 1ns / 1ps

module fned_decode (
   input  logic [7:0]             in_byte,
   input  logic                   last_of_name,
   input  fned_pkg::dec_state_type state_cur,
   output fned_pkg::dec_state_type state_nxt,
   output fned_pkg::dec_result_type result
);
   import fned_pkg::*;

   esc_result_type esc;
   logic [7:0]     lc;
   logic           valid;
   logic [7:0]     val;
   dec_state_type  st;

   assign esc = escape_lookup(in_byte);
   assign lc  = to_lower(in_byte);

   always_comb begin
      st    = state_cur;
      valid = 1'b0;
      val   = 8'h00;
      if (!state_cur.error_seen) begin
         priority if (state_cur.after_escape) begin
            unique case (esc.kind)
               ESC_TOGGLE:  st.upper_mode      = ~state_cur.upper_mode;
               ESC_CONTROL: st.control_pending = 1'b1;
               ESC_INVALID: st.error_seen      = 1'b1;
               default: begin
                  val   = esc.symbol;
                  valid = 1'b1;
               end
            endcase
            st.after_escape = 1'b0;
         end else if (in_byte == CHR_UNDERSCORE) begin
            st.after_escape = 1'b1;
         end else if (state_cur.control_pending) begin
            priority if (in_byte >= CHR_ZERO && in_byte <= CHR_NINE) begin
               val   = in_byte - CHR_ZERO;
               valid = 1'b1;
            end else if (lc >= CHR_LOWER_A && lc <= CHR_LOWER_V) begin
               val   = lc - CHR_LOWER_A + CTRL_LETTER_BASE;
               valid = 1'b1;
            end else begin
               st.error_seen = 1'b1;
            end
            st.control_pending = 1'b0;
         end else begin
            val   = state_cur.upper_mode ? to_upper(in_byte) : lc;
            valid = 1'b1;
         end
      end
      result.out_byte  = val;
      result.out_valid = valid;
      result.name_end  = last_of_name;
      result.name_bad  = last_of_name &
                         (st.error_seen | st.after_escape | st.control_pending);
      state_nxt = last_of_name ? STATE_RESET : st;
   end

endmodule

// ----- tb/tb.sv -----
// tb: self-checking testbench for file_name_escape_decoder, directed table then random names
// depends on fned_pkg and the file_name_escape_decoder top level
`timescale 1ns / 1ps

module tb;
   import fned_pkg::*;

   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 7;
   localparam int ITEM_TARGET   = 850;
   localparam int DRAIN_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int NUM_DIRECTED  = 25;

   // one row of the directed table; typed rows carry their own expected result
   typedef struct packed {
      logic [7:0]     in_byte;
      logic           last;
      logic           typed;
      dec_result_type want;
   } dir_row_type;

   localparam dec_result_type NO_OUT  = '{8'h00, 1'b0, 1'b0, 1'b0};
   localparam dec_result_type BAD_END = '{8'h00, 1'b0, 1'b1, 1'b1};
   localparam dec_result_type ANY     = '{8'h00, 1'b0, 1'b0, 1'b0};

   // walk through the extremes, every escape kind and each special case
   localparam dir_row_type DIRECTED [NUM_DIRECTED] = '{
      // plain letter right after reset: upper case mode
      '{"a",   1'b1, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b0}},
      // byte extremes pass through unchanged
      '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
      '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
      '{8'h80, 1'b0, 1'b1, '{8'h80, 1'b1, 1'b0, 1'b0}},
      // case toggle, then a letter in lower case
      '{"_",   1'b0, 1'b1, NO_OUT},
      '{"-",   1'b0, 1'b1, NO_OUT},
      '{"Q",   1'b0, 1'b0, ANY},
      // escaped symbol, matched case-blind
      '{"_",   1'b0, 1'b1, NO_OUT},
      '{"S",   1'b0, 1'b0, ANY},
      // control code with an escape in between, top code value
      '{"_",   1'b0, 1'b0, ANY},
      '{"N",   1'b0, 1'b0, ANY},
      '{"_",   1'b0, 1'b0, ANY},
      '{"x",   1'b0, 1'b0, ANY},
      '{"V",   1'b1, 1'b0, ANY},
      // unfinished control code, escape decoded on the last byte
      '{"_",   1'b0, 1'b0, ANY},
      '{"n",   1'b0, 1'b0, ANY},
      '{"_",   1'b0, 1'b0, ANY},
      '{"a",   1'b1, 1'b0, ANY},
      // high byte after an underscore is an invalid escape, then suppression
      '{"_",   1'b0, 1'b1, NO_OUT},
      '{8'hC1, 1'b0, 1'b1, NO_OUT},
      '{"z",   1'b1, 1'b1, BAD_END},
      // invalid control byte
      '{"_",   1'b0, 1'b1, NO_OUT},
      '{"n",   1'b0, 1'b1, NO_OUT},
      '{"w",   1'b1, 1'b1, BAD_END},
      // name ends on the escaping underscore
      '{"_",   1'b1, 1'b1, BAD_END}
   };

   // symbols that may follow an underscore
   localparam logic [7:0] ESC_CHARS [12] = '{
      "s", "b", "c", "a", "q", "d", "l", "g", "p", "_", "x", "u"
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_last_of_name = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_valid;
   logic       rsp_name_end;
   logic       rsp_name_bad;

   // idle rates in percent, changed per phase
   int unsigned send_idle_pct = 13;
   int unsigned recv_idle_pct = 54;

   // decoder flags of the predictor
   logic esc_open;
   logic ctrl_wait;
   logic caps_on;
   logic name_broken;

   dec_result_type pending_results [$];
   logic [7:0]     name_bytes [$];
   int unsigned    items_sent = 0;
   int unsigned    cycle_count = 0;
   bit             failed = 1'b0;

   file_name_escape_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_last_of_name (req_last_of_name),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_name_end     (rsp_name_end),
      .rsp_name_bad     (rsp_name_bad)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   function automatic logic [7:0] fold_lower(input logic [7:0] c);
      logic [7:0] f;
      f = c;
      if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) f[5] = 1'b1;
      return f;
   endfunction

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      logic [7:0] f;
      f = c;
      if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) f[5] = 1'b0;
      return f;
   endfunction

   // meaning of the byte that follows an underscore
   function automatic esc_result_type decode_escape(input logic [7:0] c);
      esc_result_type e;
      e.kind   = ESC_SYMBOL;
      e.symbol = 8'h00;
      case (fold_lower(c))
         "s":     e.symbol = "/";
         "b":     e.symbol = "\\";
         "c":     e.symbol = ":";
         "a":     e.symbol = "*";
         "q":     e.symbol = "?";
         "d":     e.symbol = "\"";
         "l":     e.symbol = "<";
         "g":     e.symbol = ">";
         "p":     e.symbol = "|";
         "_":     e.symbol = " ";
         "x":     e.symbol = ".";
         "u":     e.symbol = "_";
         "-":     e.kind = ESC_TOGGLE;
         "n":     e.kind = ESC_CONTROL;
         default: e.kind = ESC_INVALID;
      endcase
      return e;
   endfunction

   function automatic bit is_ctrl_char(input logic [7:0] c);
      logic [7:0] lc;
      lc = fold_lower(c);
      return (c >= CHR_ZERO && c <= CHR_NINE) || (lc >= CHR_LOWER_A && lc <= CHR_LOWER_V);
   endfunction

   function automatic void clear_name_state();
      esc_open    = 1'b0;
      ctrl_wait   = 1'b0;
      caps_on     = 1'b1;
      name_broken = 1'b0;
   endfunction

   // expected result of one accepted item, advancing the flags
   function automatic dec_result_type decode_byte(input logic [7:0] c, input logic last);
      dec_result_type r;
      esc_result_type e;
      logic [7:0]     lc;
      r = NO_OUT;
      if (!name_broken) begin
         if (esc_open) begin
            e = decode_escape(c);
            case (e.kind)
               ESC_TOGGLE:  caps_on = !caps_on;
               ESC_CONTROL: ctrl_wait = 1'b1;
               ESC_INVALID: name_broken = 1'b1;
               default: begin
                  r.out_byte  = e.symbol;
                  r.out_valid = 1'b1;
               end
            endcase
            esc_open = 1'b0;
         end else if (c == CHR_UNDERSCORE) begin
            // underscore wins over a pending control code
            esc_open = 1'b1;
         end else if (ctrl_wait) begin
            lc = fold_lower(c);
            if (c >= CHR_ZERO && c <= CHR_NINE) begin
               r.out_byte  = c - CHR_ZERO;
               r.out_valid = 1'b1;
            end else if (lc >= CHR_LOWER_A && lc <= CHR_LOWER_V) begin
               r.out_byte  = lc - CHR_LOWER_A + CTRL_LETTER_BASE;
               r.out_valid = 1'b1;
            end else begin
               name_broken = 1'b1;
            end
            ctrl_wait = 1'b0;
         end else begin
            r.out_byte  = caps_on ? fold_upper(c) : fold_lower(c);
            r.out_valid = 1'b1;
         end
      end
      r.name_end = last;
      r.name_bad = last && (name_broken || esc_open || ctrl_wait);
      if (last) clear_name_state();
      return r;
   endfunction

   // ---------------------------------------------------------------
   // input side
   // ---------------------------------------------------------------

   // present one item from a falling edge, wait for acceptance, record its result
   task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                            input dec_result_type want);
      dec_result_type r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_last_of_name <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = decode_byte(b, last);
      pending_results.push_back(typed ? want : r);
      items_sent++;
      @(negedge clock);
   endtask

   // random letter in random case
   function automatic logic [7:0] any_case(input logic [7:0] c);
      logic [7:0] f;
      f = c;
      if ($urandom_range(0, 1) == 1) f = fold_upper(c);
      return f;
   endfunction

   // byte that is not an underscore, letters favored
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      if ($urandom_range(0, 1) == 1)
         b = any_case(CHR_LOWER_A + 8'($urandom_range(0, 25)));
      else
         b = 8'($urandom_range(0, 255));
      if (b == CHR_UNDERSCORE) b = CHR_DASH;
      return b;
   endfunction

   function automatic logic [7:0] ctrl_byte();
      logic [7:0] b;
      if ($urandom_range(0, 2) == 0)
         b = CHR_ZERO + 8'($urandom_range(0, 9));
      else
         b = any_case(CHR_LOWER_A + 8'($urandom_range(0, 21)));
      return b;
   endfunction

   // build one encoded name in name_bytes: mostly well formed, some broken, some noise
   function automatic void build_name();
      int unsigned    tokens;
      int unsigned    k;
      logic [7:0]     b;
      esc_result_type e;
      name_bytes.delete();
      tokens = $urandom_range(1, 10);
      if ($urandom_range(0, 9) == 0) begin
         // raw noise with underscores mixed in
         repeat (tokens) begin
            b = ($urandom_range(0, 3) == 0) ? CHR_UNDERSCORE : 8'($urandom_range(0, 255));
            name_bytes.push_back(b);
         end
         return;
      end
      repeat (tokens) begin
         k = $urandom_range(0, 99);
         if (k < 45) begin
            name_bytes.push_back(plain_byte());
         end else if (k < 65) begin
            name_bytes.push_back(CHR_UNDERSCORE);
            name_bytes.push_back(any_case(ESC_CHARS[$urandom_range(0, 11)]));
         end else if (k < 73) begin
            name_bytes.push_back(CHR_UNDERSCORE);
            name_bytes.push_back(CHR_DASH);
         end else if (k < 89) begin
            name_bytes.push_back(CHR_UNDERSCORE);
            name_bytes.push_back(any_case("n"));
            // sometimes an escape sits between the start and the code byte
            if ($urandom_range(0, 5) == 0) begin
               name_bytes.push_back(CHR_UNDERSCORE);
               name_bytes.push_back(any_case(ESC_CHARS[$urandom_range(0, 11)]));
            end
            name_bytes.push_back(ctrl_byte());
         end else if (k < 94) begin
            do begin
               b = 8'($urandom_range(0, 255));
               e = decode_escape(b);
            end while (e.kind != ESC_INVALID);
            name_bytes.push_back(CHR_UNDERSCORE);
            name_bytes.push_back(b);
         end else if (k < 98) begin
            do b = 8'($urandom_range(0, 255));
            while (is_ctrl_char(b) || b == CHR_UNDERSCORE);
            name_bytes.push_back(CHR_UNDERSCORE);
            name_bytes.push_back(any_case("n"));
            name_bytes.push_back(b);
         end else begin
            name_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
      // now and then leave an escape open at the end
      k = $urandom_range(0, 99);
      if (k < 4) begin
         name_bytes.push_back(CHR_UNDERSCORE);
      end else if (k < 8) begin
         name_bytes.push_back(CHR_UNDERSCORE);
         name_bytes.push_back(any_case("n"));
      end
   endfunction

   // ---------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------

   // receiver stalls at random, decided on the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         failed = 1'b1;
      end
   endtask

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      dec_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, got byte %0h valid %0b end %0b bad %0b",
                     $time, rsp_out_byte, rsp_out_valid, rsp_name_end, rsp_name_bad);
            failed = 1'b1;
         end else begin
            want = pending_results.pop_front();
            check_field("out_byte", want.out_byte, rsp_out_byte);
            check_field("out_valid", want.out_valid, rsp_out_valid);
            check_field("name_end", want.name_end, rsp_name_end);
            check_field("name_bad", want.name_bad, rsp_name_bad);
         end
      end
   end

   // hard stop if the handshakes hang
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------

   initial begin
      clear_name_state();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_byte(DIRECTED[i].in_byte, DIRECTED[i].last, DIRECTED[i].typed,
                   DIRECTED[i].want);
      end

      // random names; idle profile swaps after a third, then stops
      while (items_sent < NUM_DIRECTED + ITEM_TARGET) begin
         if (items_sent >= NUM_DIRECTED + 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (items_sent >= NUM_DIRECTED + ITEM_TARGET / 3) begin
            send_idle_pct = 54;
            recv_idle_pct = 13;
         end
         build_name();
         foreach (name_bytes[j]) begin
            send_byte(name_bytes[j], j == name_bytes.size() - 1, 1'b0, NO_OUT);
         end
      end
      req_valid <= 1'b0;

      // drain, then wait for any stray result
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
